// ===== rtl/ptrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptrf_pkg;

   localparam int PEER_SLOTS_DEFAULT = 8;

   localparam int MODE_W   = 2;
   localparam int MAC_W    = 48;
   localparam int MEMBER_W = 8;
   localparam int SEQ_W    = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 3;

   localparam logic [MODE_W-1:0] MODE_LEARN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACCEPT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MAC_REFUSED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_STALE       = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH    = 3'd5;

   typedef struct packed {
      logic                valid;
      logic [MAC_W-1:0]    mac;
      logic [MEMBER_W-1:0] member;
      logic [SEQ_W-1:0]    seq;
   } entry_type;

   typedef struct packed {
      logic mac_en;
      logic seq_en;
      logic set_valid;
      logic clear_all;
   } wr_type;

   typedef struct packed {
      logic mac_eq;
      logic member_eq;
      logic seq_le;
   } match_type;

endpackage

`default_nettype wire

// ===== rtl/ptrf_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptrf_store #(
   parameter int PEER_SLOTS = ptrf_pkg::PEER_SLOTS_DEFAULT,
   parameter int IDX_W      = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              rd_idx,
   output ptrf_pkg::entry_type           entry,
   input  ptrf_pkg::wr_type              wr,
   input  logic [IDX_W-1:0]              wr_idx,
   input  logic [ptrf_pkg::MAC_W-1:0]    wr_mac,
   input  logic [ptrf_pkg::MEMBER_W-1:0] wr_member,
   input  logic [ptrf_pkg::SEQ_W-1:0]    wr_seq
);
   import ptrf_pkg::*;

   logic [MAC_W-1:0]    mac_mem_ff    [PEER_SLOTS];
   logic [MEMBER_W-1:0] member_mem_ff [PEER_SLOTS];
   logic [SEQ_W-1:0]    seq_mem_ff    [PEER_SLOTS];

   logic [PEER_SLOTS-1:0] valid_ff;
   logic [PEER_SLOTS-1:0] valid_in;
   logic [PEER_SLOTS-1:0] seq_written_ff;
   logic [PEER_SLOTS-1:0] seq_written_in;

   logic                rd_valid_ff;
   logic [MAC_W-1:0]    rd_mac_ff;
   logic [MEMBER_W-1:0] rd_member_ff;
   logic [SEQ_W-1:0]    rd_seq_ff;
   logic                rd_seq_written_ff;

   always_comb begin
      valid_in       = valid_ff;
      seq_written_in = seq_written_ff;
      if (wr.clear_all) begin
         valid_in = '0;
      end else if (wr.set_valid) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (wr.seq_en) begin
         seq_written_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         seq_written_ff <= '0;
      end else begin
         valid_ff       <= valid_in;
         seq_written_ff <= seq_written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.mac_en) begin
         mac_mem_ff[wr_idx]    <= wr_mac;
         member_mem_ff[wr_idx] <= wr_member;
      end
      if (wr.seq_en) begin
         seq_mem_ff[wr_idx] <= wr_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff       <= valid_ff[rd_idx];
         rd_mac_ff         <= mac_mem_ff[rd_idx];
         rd_member_ff      <= member_mem_ff[rd_idx];
         rd_seq_ff         <= seq_mem_ff[rd_idx];
         rd_seq_written_ff <= seq_written_ff[rd_idx];
      end
   end

   // A sequence slot that was never written reads as zero.
   assign entry.valid  = rd_valid_ff;
   assign entry.mac    = rd_mac_ff;
   assign entry.member = rd_member_ff;
   assign entry.seq    = rd_seq_written_ff ? rd_seq_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/ptrf_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptrf_match (
   input  logic [ptrf_pkg::MAC_W-1:0]    op_mac,
   input  logic [ptrf_pkg::MEMBER_W-1:0] op_member,
   input  logic [ptrf_pkg::SEQ_W-1:0]    op_seq,
   input  ptrf_pkg::entry_type           entry,
   output ptrf_pkg::match_type           match
);
   import ptrf_pkg::*;

   assign match.mac_eq    = (entry.mac == op_mac);
   assign match.member_eq = (entry.member == op_member);
   assign match.seq_le    = (op_seq <= entry.seq);

endmodule

`default_nettype wire

// ===== rtl/peer_table_replay_filter_top.sv =====
// Peer table with a per-peer sequence replay check.
// Requests arrive on the req_ channel (valid/stall); each request transfer
// yields exactly one response transfer on the rsp_ channel, in order.
// Modes: learn a peer, accept a sequence number, look up a member, clear.
// The csr_ port writes the provisioned flag; write it only while idle.
// A match ends the slot scan early. The scan reads one slot per cycle
// from the slot memory through one shared comparator. req_stall stays
// high from the request transfer until the response is loaded into the
// output register, so one request is handled at a time. A response
// stalled by rsp_stall holds its payload, and a finished request then
// waits before writing the table or taking a new one. A clear skips the
// scan and empties the table at its request transfer.
// Reset (synchronous, active high) drops all valid marks, zeroes every
// stored sequence number, clears the provisioned flag and empties the
// output register.
`timescale 1ns / 1ps
`default_nettype none

module peer_table_replay_filter_top #(
   parameter int PEER_SLOTS = ptrf_pkg::PEER_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ptrf_pkg::MODE_W-1:0]   req_mode,
   input  logic [ptrf_pkg::MAC_W-1:0]    req_peer_mac,
   input  logic [ptrf_pkg::MEMBER_W-1:0] req_member_id,
   input  logic [ptrf_pkg::SEQ_W-1:0]    req_sequence_req,
   input  logic                          req_reset_window,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ptrf_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_found,
   output logic [ptrf_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [ptrf_pkg::MAC_W-1:0]    rsp_found_mac
);
   import ptrf_pkg::*;

   localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CNT_W = $clog2(PEER_SLOTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PUT} state_type;
   typedef enum logic [1:0] {WR_NONE, WR_UPDATE, WR_SEQ, WR_NEW} wr_kind_type;

   state_type            state_ff, state_in;
   logic                 provisioned_ff;
   logic [MODE_W-1:0]    op_mode_ff, op_mode_in;
   logic [MAC_W-1:0]     op_mac_ff, op_mac_in;
   logic [MEMBER_W-1:0]  op_member_ff, op_member_in;
   logic [SEQ_W-1:0]     op_seq_ff, op_seq_in;
   logic                 op_rst_ff, op_rst_in;
   logic [CNT_W-1:0]     iss_ff, iss_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 free_seen_ff, free_seen_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   wr_kind_type          wr_kind_ff, wr_kind_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [MAC_W-1:0]     res_mac_ff, res_mac_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [MAC_W-1:0]     rsp_found_mac_ff, rsp_found_mac_in;

   logic                 req_take;
   logic                 out_free;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_idx;
   entry_type            entry;
   match_type            match;
   wr_type               wr;
   logic                 last_slot;
   logic                 free_now;
   logic [IDX_W-1:0]     free_idx_now;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_en = (state_ff == ST_SCAN) && (iss_ff < CNT_W'(PEER_SLOTS));
   assign rd_idx = iss_ff[IDX_W-1:0];

   always_comb begin
      wr = '0;
      if (state_ff == ST_PUT && out_free) begin
         wr.mac_en    = (wr_kind_ff == WR_UPDATE) || (wr_kind_ff == WR_NEW);
         wr.seq_en    = (wr_kind_ff == WR_SEQ);
         wr.set_valid = (wr_kind_ff == WR_NEW);
      end
      wr.clear_all = req_take && (req_mode == MODE_CLEAR);
   end

   ptrf_store #(
      .PEER_SLOTS (PEER_SLOTS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_idx    (rd_idx),
      .entry     (entry),
      .wr        (wr),
      .wr_idx    (res_idx_ff),
      .wr_mac    (op_mac_ff),
      .wr_member (op_member_ff),
      .wr_seq    (op_seq_ff)
   );

   ptrf_match u_match (
      .op_mac    (op_mac_ff),
      .op_member (op_member_ff),
      .op_seq    (op_seq_ff),
      .entry     (entry),
      .match     (match)
   );

   assign last_slot    = chk_vld_ff && (chk_idx_ff == IDX_W'(PEER_SLOTS - 1));
   assign free_now     = free_seen_ff || !entry.valid;
   assign free_idx_now = free_seen_ff ? free_idx_ff : chk_idx_ff;

   always_comb begin
      state_in         = state_ff;
      op_mode_in       = op_mode_ff;
      op_mac_in        = op_mac_ff;
      op_member_in     = op_member_ff;
      op_seq_in        = op_seq_ff;
      op_rst_in        = op_rst_ff;
      iss_in           = iss_ff;
      chk_vld_in       = 1'b0;
      chk_idx_in       = chk_idx_ff;
      free_seen_in     = free_seen_ff;
      free_idx_in      = free_idx_ff;
      wr_kind_in       = wr_kind_ff;
      res_idx_in       = res_idx_ff;
      res_status_in    = res_status_ff;
      res_found_in     = res_found_ff;
      res_mac_in       = res_mac_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_found_mac_in = rsp_found_mac_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_mode_in    = req_mode;
               op_mac_in     = req_peer_mac;
               op_member_in  = req_member_id;
               op_seq_in     = req_sequence_req;
               op_rst_in     = req_reset_window;
               iss_in        = '0;
               free_seen_in  = 1'b0;
               free_idx_in   = '0;
               wr_kind_in    = WR_NONE;
               res_idx_in    = '0;
               res_status_in = STATUS_OK;
               res_found_in  = 1'b0;
               res_mac_in    = '0;
               if (req_mode == MODE_CLEAR) begin
                  state_in = ST_PUT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               iss_in     = iss_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx;
            end
            if (chk_vld_ff) begin
               case (op_mode_ff)
                  MODE_LEARN: begin
                     if (entry.valid && (match.member_eq || match.mac_eq)) begin
                        state_in     = ST_PUT;
                        res_found_in = 1'b1;
                        res_idx_in   = chk_idx_ff;
                        if (provisioned_ff && !match.mac_eq) begin
                           res_status_in = STATUS_MAC_REFUSED;
                        end else begin
                           res_status_in = STATUS_OK;
                           wr_kind_in    = WR_UPDATE;
                        end
                     end else begin
                        free_seen_in = free_now;
                        free_idx_in  = free_idx_now;
                        if (last_slot) begin
                           state_in = ST_PUT;
                           if (provisioned_ff) begin
                              res_status_in = STATUS_UNKNOWN;
                           end else if (free_now) begin
                              res_status_in = STATUS_OK;
                              res_found_in  = 1'b1;
                              res_idx_in    = free_idx_now;
                              wr_kind_in    = WR_NEW;
                           end else begin
                              res_status_in = STATUS_FULL;
                           end
                        end
                     end
                  end
                  MODE_ACCEPT: begin
                     if (entry.valid && match.mac_eq) begin
                        state_in     = ST_PUT;
                        res_found_in = 1'b1;
                        res_idx_in   = chk_idx_ff;
                        if (!op_rst_ff && match.seq_le) begin
                           res_status_in = STATUS_STALE;
                        end else begin
                           res_status_in = STATUS_OK;
                           wr_kind_in    = WR_SEQ;
                        end
                     end else if (last_slot) begin
                        state_in      = ST_PUT;
                        res_status_in = STATUS_NO_MATCH;
                     end
                  end
                  MODE_LOOKUP: begin
                     if (entry.valid && match.member_eq) begin
                        state_in      = ST_PUT;
                        res_found_in  = 1'b1;
                        res_idx_in    = chk_idx_ff;
                        res_status_in = STATUS_OK;
                        res_mac_in    = entry.mac;
                     end else if (last_slot) begin
                        state_in      = ST_PUT;
                        res_status_in = STATUS_NO_MATCH;
                     end
                  end
                  default: begin
                     state_in = ST_PUT;
                  end
               endcase
            end
         end
         ST_PUT: begin
            if (out_free) begin
               state_in         = ST_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_found_in     = res_found_ff;
               rsp_slot_in      = res_found_ff ? SLOT_W'(res_idx_ff) : '0;
               rsp_found_mac_in = res_mac_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         provisioned_ff <= 1'b0;
         chk_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff         <= state_in;
         chk_vld_ff       <= chk_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_write_enable) begin
            provisioned_ff <= csr_write_data;
         end
         op_mode_ff       <= op_mode_in;
         op_mac_ff        <= op_mac_in;
         op_member_ff     <= op_member_in;
         op_seq_ff        <= op_seq_in;
         op_rst_ff        <= op_rst_in;
         iss_ff           <= iss_in;
         chk_idx_ff       <= chk_idx_in;
         free_seen_ff     <= free_seen_in;
         free_idx_ff      <= free_idx_in;
         wr_kind_ff       <= wr_kind_in;
         res_idx_ff       <= res_idx_in;
         res_status_ff    <= res_status_in;
         res_found_ff     <= res_found_in;
         res_mac_ff       <= res_mac_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_found_ff     <= rsp_found_in;
         rsp_slot_ff      <= rsp_slot_in;
         rsp_found_mac_ff <= rsp_found_mac_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_found_mac = rsp_found_mac_ff;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ptrf_pkg::*;

   localparam int PEER_SLOTS    = PEER_SLOTS_DEFAULT;
   localparam int SETTLE_CYCLES = PEER_SLOTS + 8;
   localparam int END_CYCLES    = 4 * (PEER_SLOTS + 3);
   localparam int CYCLE_LIMIT   = 300000;
   localparam int POOL_SIZE     = 10;
   localparam int PHASES        = 7;
   localparam int PHASE_OPS     = 98;

   typedef enum logic [1:0] {
      OP_REQUEST,
      OP_SET_PROVISIONED,
      OP_DRAIN
   } op_kind_type;

   typedef struct {
      op_kind_type         kind;
      logic [MODE_W-1:0]   mode;
      logic [MAC_W-1:0]    mac;
      logic [MEMBER_W-1:0] member;
      logic [SEQ_W-1:0]    seq;
      logic                reset_window;
      logic                cfg_value;
      int                  gap;
      int                  stall_pct;
   } table_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [SLOT_W-1:0]   slot;
      logic [MAC_W-1:0]    found_mac;
   } peer_rsp_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [MODE_W-1:0] req_mode = MODE_LEARN;
   logic [MAC_W-1:0] req_peer_mac = '0;
   logic [MEMBER_W-1:0] req_member_id = '0;
   logic [SEQ_W-1:0] req_sequence_req = '0;
   logic req_reset_window = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_found;
   logic [SLOT_W-1:0] rsp_slot;
   logic [MAC_W-1:0] rsp_found_mac;

   peer_table_replay_filter_top #(
      .PEER_SLOTS(PEER_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_peer_mac(req_peer_mac),
      .req_member_id(req_member_id),
      .req_sequence_req(req_sequence_req),
      .req_reset_window(req_reset_window),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_slot(rsp_slot),
      .rsp_found_mac(rsp_found_mac)
   );

   // Shadow copy of the peer table and the provisioned flag.
   logic                tbl_valid [PEER_SLOTS];
   logic [MAC_W-1:0]    tbl_mac [PEER_SLOTS];
   logic [MEMBER_W-1:0] tbl_member [PEER_SLOTS];
   logic [SEQ_W-1:0]    tbl_seq [PEER_SLOTS];
   logic                prov_flag = 1'b0;

   table_op_type pending_ops[$];
   peer_rsp_type expected_rsps[$];

   int errors = 0;
   int cycles = 0;
   int sent_count = 0;
   int cfg_count = 0;
   int status_seen [8];
   int cur_gap_pct = 0;
   int cur_stall_pct = 0;
   int rsp_stall_pct = 0;

   logic [MAC_W-1:0]    pool_mac [POOL_SIZE];
   logic [MEMBER_W-1:0] pool_member [POOL_SIZE];
   logic [SEQ_W-1:0]    pool_seq [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_mac[i] = '0;
         tbl_member[i] = '0;
         tbl_seq[i] = '0;
      end
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
   end

   task automatic predict_peer_table(input table_op_type op);
      peer_rsp_type r;
      int hit;
      int i;
      r.status = STATUS_OK;
      r.found = 1'b0;
      r.slot = '0;
      r.found_mac = '0;
      hit = -1;
      case (op.mode)
         MODE_LEARN: begin
            for (i = 0; i < PEER_SLOTS; i++)
               if (hit < 0 && tbl_valid[i] && (tbl_member[i] == op.member || tbl_mac[i] == op.mac))
                  hit = i;
            if (hit >= 0) begin
               if (prov_flag && tbl_mac[hit] != op.mac) begin
                  r.status = STATUS_MAC_REFUSED;
               end else begin
                  tbl_mac[hit] = op.mac;
                  tbl_member[hit] = op.member;
               end
            end else if (prov_flag) begin
               r.status = STATUS_UNKNOWN;
            end else begin
               for (i = 0; i < PEER_SLOTS; i++)
                  if (hit < 0 && !tbl_valid[i]) hit = i;
               if (hit >= 0) begin
                  tbl_mac[hit] = op.mac;
                  tbl_member[hit] = op.member;
                  tbl_valid[hit] = 1'b1;
               end else begin
                  r.status = STATUS_FULL;
               end
            end
         end
         MODE_ACCEPT: begin
            for (i = 0; i < PEER_SLOTS; i++)
               if (hit < 0 && tbl_valid[i] && tbl_mac[i] == op.mac) hit = i;
            if (hit < 0) begin
               r.status = STATUS_NO_MATCH;
            end else if (!op.reset_window && op.seq <= tbl_seq[hit]) begin
               r.status = STATUS_STALE;
            end else begin
               tbl_seq[hit] = op.seq;
            end
         end
         MODE_LOOKUP: begin
            for (i = 0; i < PEER_SLOTS; i++)
               if (hit < 0 && tbl_valid[i] && tbl_member[i] == op.member) hit = i;
            if (hit < 0) r.status = STATUS_NO_MATCH;
            else r.found_mac = tbl_mac[hit];
         end
         default: begin
            for (i = 0; i < PEER_SLOTS; i++) tbl_valid[i] = 1'b0;
         end
      endcase
      if (hit >= 0) begin
         r.found = 1'b1;
         r.slot = hit[SLOT_W-1:0];
      end
      expected_rsps.push_back(r);
   endtask

   task automatic push_req(input logic [MODE_W-1:0] mode, input logic [MAC_W-1:0] mac,
                           input logic [MEMBER_W-1:0] member, input logic [SEQ_W-1:0] seq,
                           input logic rst);
      table_op_type op;
      op.kind = OP_REQUEST;
      op.mode = mode;
      op.mac = mac;
      op.member = member;
      op.seq = seq;
      op.reset_window = rst;
      op.cfg_value = 1'b0;
      op.gap = ($urandom_range(0, 99) < cur_gap_pct) ? $urandom_range(1, 15) : 0;
      op.stall_pct = cur_stall_pct;
      pending_ops.push_back(op);
   endtask

   task automatic push_marker(input op_kind_type kind, input logic value);
      table_op_type op;
      op.kind = kind;
      op.mode = MODE_LEARN;
      op.mac = '0;
      op.member = '0;
      op.seq = '0;
      op.reset_window = 1'b0;
      op.cfg_value = value;
      op.gap = 0;
      op.stall_pct = cur_stall_pct;
      pending_ops.push_back(op);
   endtask

   task automatic add_random_op();
      int p;
      int pick;
      int sel;
      logic [MAC_W-1:0] mac;
      logic [MEMBER_W-1:0] member;
      logic [SEQ_W-1:0] seq;
      logic rst;
      p = $urandom_range(0, POOL_SIZE - 1);
      pick = $urandom_range(0, 99);
      rst = ($urandom_range(0, 9) == 0);
      if (pick < 33) begin
         mac = pool_mac[p];
         member = pool_member[p];
         // A known member announcing another peer's MAC.
         if ($urandom_range(0, 9) == 0) mac = pool_mac[$urandom_range(0, POOL_SIZE - 1)];
         push_req(MODE_LEARN, mac, member, $urandom, rst);
      end else if (pick < 73) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            seq = pool_seq[p] + $urandom_range(1, 1000);
            pool_seq[p] = seq;
         end else if (sel < 8) begin
            seq = pool_seq[p] - $urandom_range(0, 2);
         end else if (sel == 8) begin
            seq = $urandom;
         end else begin
            seq = $urandom_range(0, 1) ? '1 : '0;
         end
         push_req(MODE_ACCEPT, pool_mac[p], pool_member[p], seq, rst);
      end else if (pick < 86) begin
         member = ($urandom_range(0, 9) == 0) ? MEMBER_W'($urandom) : pool_member[p];
         push_req(MODE_LOOKUP, MAC_W'({$urandom, $urandom}), member, $urandom, rst);
      end else if (pick < 88) begin
         push_req(MODE_CLEAR, MAC_W'({$urandom, $urandom}), MEMBER_W'($urandom), $urandom,
                  rst);
      end else begin
         push_req(MODE_W'($urandom_range(0, 2)), MAC_W'({$urandom, $urandom}),
                  MEMBER_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
      end
   endtask

   // Driver: presents queued requests and performs register writes while idle.
   logic drv_busy;
   logic drv_next_valid;
   logic drv_next_we;
   logic gap_armed = 1'b0;
   int gap_left = 0;
   int settle_count = 0;
   table_op_type head_op;
   table_op_type cur_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_write_enable <= 1'b0;
         gap_armed = 1'b0;
         gap_left = 0;
         settle_count = 0;
      end else begin
         drv_busy = req_valid;
         if (req_valid && !req_stall) begin
            predict_peer_table(cur_req);
            sent_count++;
            drv_busy = 1'b0;
         end
         drv_next_valid = drv_busy;
         drv_next_we = 1'b0;
         if (!drv_busy && pending_ops.size() != 0) begin
            head_op = pending_ops[0];
            if (head_op.kind == OP_REQUEST) begin
               settle_count = 0;
               if (!gap_armed) begin
                  gap_left = head_op.gap;
                  gap_armed = 1'b1;
               end
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  head_op = pending_ops.pop_front();
                  gap_armed = 1'b0;
                  cur_req = head_op;
                  drv_next_valid = 1'b1;
                  req_mode <= head_op.mode;
                  req_peer_mac <= head_op.mac;
                  req_member_id <= head_op.member;
                  req_sequence_req <= head_op.seq;
                  req_reset_window <= head_op.reset_window;
                  rsp_stall_pct <= head_op.stall_pct;
               end
            end else if (expected_rsps.size() != 0) begin
               settle_count = 0;
            end else if (settle_count < SETTLE_CYCLES) begin
               settle_count++;
            end else begin
               settle_count = 0;
               head_op = pending_ops.pop_front();
               rsp_stall_pct <= head_op.stall_pct;
               if (head_op.kind == OP_SET_PROVISIONED) begin
                  drv_next_we = 1'b1;
                  csr_write_data <= head_op.cfg_value;
                  prov_flag = head_op.cfg_value;
                  cfg_count++;
               end
            end
         end
         req_valid <= drv_next_valid;
         csr_write_enable <= drv_next_we;
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h actual %0h", name, want, got);
         errors++;
      end
   endtask

   // Monitor: checks each response transfer and stalls the result side in bursts.
   peer_rsp_type want_rsp;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response transfer with no request outstanding");
               errors++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               check_field("status", 64'(want_rsp.status), 64'(rsp_status));
               check_field("found", 64'(want_rsp.found), 64'(rsp_found));
               check_field("slot", 64'(want_rsp.slot), 64'(rsp_slot));
               check_field("found_mac", 64'(want_rsp.found_mac), 64'(rsp_found_mac));
               status_seen[want_rsp.status]++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   int phase_gap [PHASES] = '{20, 0, 35, 10, 50, 5, 0};
   int phase_stall [PHASES] = '{10, 25, 0, 5, 30, 0, 0};
   logic phase_prov [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_mac[i] = MAC_W'({$urandom, $urandom});
         pool_member[i] = MEMBER_W'($urandom);
         pool_seq[i] = $urandom_range(0, 5000);
      end

      cur_gap_pct = 15;
      cur_stall_pct = 10;
      push_marker(OP_SET_PROVISIONED, 1'b0);
      push_req(MODE_LOOKUP, '0, 8'h00, '0, 1'b0);
      push_req(MODE_ACCEPT, '0, 8'h00, '0, 1'b0);
      push_req(MODE_LEARN, 48'h0000_0000_0000, 8'h00, '1, 1'b1);
      push_req(MODE_LEARN, 48'hFFFF_FFFF_FFFF, 8'hFF, '0, 1'b0);
      push_req(MODE_LEARN, 48'h0000_0000_0001, 8'h01, '0, 1'b0);
      push_req(MODE_LEARN, 48'h8000_0000_0000, 8'h80, '0, 1'b0);
      push_req(MODE_LEARN, 48'h0123_4567_89AB, 8'h55, '0, 1'b0);
      push_req(MODE_LEARN, 48'hAAAA_AAAA_AAAA, 8'hAA, '0, 1'b0);
      push_req(MODE_LEARN, 48'h5555_5555_5555, 8'h7F, '0, 1'b0);
      push_req(MODE_LEARN, 48'hFEDC_BA98_7654, 8'h3C, '0, 1'b0);
      // The table is full now, so a ninth peer is turned away.
      push_req(MODE_LEARN, 48'h0000_1111_2222, 8'h99, '0, 1'b0);
      push_req(MODE_LEARN, 48'h0000_0000_0002, 8'h01, '0, 1'b0);
      push_req(MODE_ACCEPT, 48'h0000_0000_0000, 8'h00, '0, 1'b0);
      push_req(MODE_ACCEPT, 48'hFFFF_FFFF_FFFF, 8'hFF, '1, 1'b0);
      push_req(MODE_ACCEPT, 48'hFFFF_FFFF_FFFF, 8'hFF, 32'd5, 1'b1);
      push_req(MODE_ACCEPT, 48'hFFFF_FFFF_FFFF, 8'hFF, 32'd5, 1'b0);
      push_req(MODE_LOOKUP, '1, 8'hFF, '1, 1'b1);
      push_marker(OP_SET_PROVISIONED, 1'b1);
      push_req(MODE_LEARN, 48'hFFFF_FFFF_FFFF, 8'hFF, '0, 1'b0);
      push_req(MODE_LEARN, 48'h0000_0000_0123, 8'h00, '0, 1'b0);
      push_req(MODE_LEARN, 48'h0000_1111_2222, 8'h99, '0, 1'b0);
      push_req(MODE_LEARN, 48'hFFFF_FFFF_FFFF, 8'h44, '0, 1'b0);
      push_req(MODE_CLEAR, '1, 8'hFF, '1, 1'b1);
      push_req(MODE_LOOKUP, '0, 8'h44, '0, 1'b0);
      push_req(MODE_ACCEPT, 48'hFFFF_FFFF_FFFF, 8'h44, 32'd100, 1'b0);
      push_marker(OP_SET_PROVISIONED, 1'b0);
      // A peer placed after a clear inherits the old window of its slot.
      push_req(MODE_LEARN, 48'h0000_1111_2222, 8'h99, '0, 1'b0);
      push_req(MODE_ACCEPT, 48'h0000_1111_2222, 8'h99, '0, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         cur_gap_pct = phase_gap[ph];
         cur_stall_pct = phase_stall[ph];
         for (int k = 0; k < 3; k++) begin
            pool_mac[$urandom_range(0, POOL_SIZE - 1)] = MAC_W'({$urandom, $urandom});
            pool_member[$urandom_range(0, POOL_SIZE - 1)] = MEMBER_W'($urandom);
         end
         push_marker(OP_SET_PROVISIONED, phase_prov[ph]);
         for (int n = 0; n < PHASE_OPS; n++) begin
            if ((ph == 2 || ph == 4) && n == PHASE_OPS / 2) push_marker(OP_DRAIN, 1'b0);
            add_random_op();
         end
      end

      while (pending_ops.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d expected responses never arrived", expected_rsps.size());
         errors++;
      end
      $display("Run covered %0d request transfers across %0d writes of the provisioned flag.",
               sent_count, cfg_count);
      $display("Statuses: ok %0d, MAC refused %0d, unknown %0d, full %0d, stale %0d, none %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_MAC_REFUSED],
               status_seen[STATUS_UNKNOWN], status_seen[STATUS_FULL],
               status_seen[STATUS_STALE], status_seen[STATUS_NO_MATCH]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
